### rtl/cwfs_pkg.sv
// ----------------------------------------------------------------------------
// cwfs_pkg: shared types and constants for the credit window frame sender
// Result kinds, widths, controller state encoding and the command/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package cwfs_pkg;

    localparam int TAG_W    = 16;
    localparam int CREDIT_W = 16;
    localparam int KIND_W   = 2;
    localparam int ENTRY_W  = TAG_W + 1;   // final flag above the tag

    localparam logic [CREDIT_W-1:0] CREDIT_RESET = 16'd16;
    localparam logic [CREDIT_W-1:0] CREDIT_MAX   = 16'hFFFF;

    localparam logic [KIND_W-1:0] KIND_FRAME = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP  = 2'd2;

    localparam logic REQ_LOCAL = 1'b0;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DISPATCH = 6'b000010,
        ST_FETCH    = 6'b000100,
        ST_CHECK    = 6'b001000,
        ST_NEWITEM  = 6'b010000,
        ST_FINISH   = 6'b100000
    } state_t;

    typedef struct packed {
        logic load_item;   // capture accepted transaction
        logic credit_inc;  // partner ack: one more credit, saturating
        logic send_head;   // release queue head as a frame
        logic send_new;    // send the held local frame
        logic enqueue;     // queue the held local frame
        logic drop;        // report the held local frame as dropped
        logic emit_ack;    // emit an ack
        logic flush;       // close the transaction's results
    } cmd_t;

    typedef struct packed {
        logic req_type;
        logic frame_final;
        logic data_present;
        logic head_ok;       // queue head may leave now
        logic credit_zero;
        logic queue_full;
        logic stage_blocked; // a new result cannot be staged this cycle
    } status_t;

endpackage

### rtl/credit_window_frame_sender.sv
// ----------------------------------------------------------------------------
// credit_window_frame_sender: sending side of a credit flow controlled exchange
// Sends, queues or drops local frames against a credit window, releases queued
// frames as credit allows, and answers non-final partner data frames with acks.
//
//   channel   direction  handshake             payload
//   s_        in         s_valid / s_ready     s_req_type, s_frame_tag,
//                                              s_is_final, s_has_payload
//   m_        out        m_valid / m_ready     out_kind, out_tag, last
//   cfg_      in         cfg_valid / cfg_ready initial_window (loads credit)
//
// One transaction at a time. A local send: dispatch, a fetch and check per
// frame released and a last one, new frame, finish. A partner ack: the same
// without new frame. A partner data frame: dispatch, finish. Fetch waits on
// the registered queue head read. Results are held one deep and leave
// through an output register, so a stall on m_ready holds the sequence
// without loss. Synchronous active-low reset: credit back to 16, queue empty.
// ----------------------------------------------------------------------------
module credit_window_frame_sender #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cwfs_pkg::CREDIT_W-1:0] cfg_initial_window,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [cwfs_pkg::TAG_W-1:0]    s_frame_tag,
    input  logic                          s_is_final,
    input  logic                          s_has_payload,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [cwfs_pkg::KIND_W-1:0]   m_out_kind,
    output logic [cwfs_pkg::TAG_W-1:0]    m_out_tag,
    output logic                          m_last
);

    cwfs_pkg::cmd_t    cmd;
    cwfs_pkg::status_t status;

    assign cfg_ready = 1'b1;

    cwfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cwfs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_write          (cfg_valid && cfg_ready),
        .cfg_initial_window (cfg_initial_window),
        .s_req_type         (s_req_type),
        .s_frame_tag        (s_frame_tag),
        .s_is_final         (s_is_final),
        .s_has_payload      (s_has_payload),
        .cmd                (cmd),
        .status             (status),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_kind         (m_out_kind),
        .m_out_tag          (m_out_tag),
        .m_last             (m_last)
    );

endmodule

### rtl/cwfs_ctrl.sv
// ----------------------------------------------------------------------------
// cwfs_ctrl: sequencing controller
// Walks one transaction at a time through dispatch, queue drain, handling of
// the new frame and the close of its results.
// ----------------------------------------------------------------------------
module cwfs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cwfs_pkg::status_t status,
    output cwfs_pkg::cmd_t    cmd
);

    cwfs_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cwfs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            cwfs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = cwfs_pkg::ST_DISPATCH;
                end
            end
            cwfs_pkg::ST_DISPATCH: begin
                if (status.req_type == cwfs_pkg::REQ_LOCAL) begin
                    state_next = cwfs_pkg::ST_FETCH;
                end else if (!status.data_present) begin
                    cmd.credit_inc = 1'b1;
                    state_next     = cwfs_pkg::ST_FETCH;
                end else if (!status.frame_final) begin
                    if (!status.stage_blocked) begin
                        cmd.emit_ack = 1'b1;
                        state_next   = cwfs_pkg::ST_FINISH;
                    end
                end else begin
                    state_next = cwfs_pkg::ST_FINISH;
                end
            end
            cwfs_pkg::ST_FETCH: begin
                // head entry read data lands at the end of this cycle
                state_next = cwfs_pkg::ST_CHECK;
            end
            cwfs_pkg::ST_CHECK: begin
                if (status.head_ok) begin
                    if (!status.stage_blocked) begin
                        cmd.send_head = 1'b1;
                        state_next    = cwfs_pkg::ST_FETCH;
                    end
                end else if (status.req_type == cwfs_pkg::REQ_LOCAL) begin
                    state_next = cwfs_pkg::ST_NEWITEM;
                end else begin
                    state_next = cwfs_pkg::ST_FINISH;
                end
            end
            cwfs_pkg::ST_NEWITEM: begin
                if (status.credit_zero && !status.queue_full) begin
                    cmd.enqueue = 1'b1;
                    state_next  = cwfs_pkg::ST_FINISH;
                end else if (!status.stage_blocked) begin
                    cmd.drop     = status.credit_zero;
                    cmd.send_new = !status.credit_zero;
                    state_next   = cwfs_pkg::ST_FINISH;
                end
            end
            cwfs_pkg::ST_FINISH: begin
                if (!status.stage_blocked) begin
                    cmd.flush  = 1'b1;
                    state_next = cwfs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cwfs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/cwfs_datapath.sv
// ----------------------------------------------------------------------------
// cwfs_datapath: credit counter, pending frame queue and result path
// One result is held back in a stage register so that the last flag can be
// set once it is known whether another result follows.
// ----------------------------------------------------------------------------
module cwfs_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_write,
    input  logic [cwfs_pkg::CREDIT_W-1:0]      cfg_initial_window,
    input  logic                               s_req_type,
    input  logic [cwfs_pkg::TAG_W-1:0]         s_frame_tag,
    input  logic                               s_is_final,
    input  logic                               s_has_payload,
    input  cwfs_pkg::cmd_t                     cmd,
    output cwfs_pkg::status_t                  status,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [cwfs_pkg::KIND_W-1:0]        m_out_kind,
    output logic [cwfs_pkg::TAG_W-1:0]         m_out_tag,
    output logic                               m_last
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                            item_type_reg;
    logic [cwfs_pkg::TAG_W-1:0]      item_tag_reg;
    logic                            item_final_reg;
    logic                            item_payload_reg;

    logic [cwfs_pkg::CREDIT_W-1:0]   credit_reg;
    logic [PTR_W-1:0]                head_reg;
    logic [PTR_W-1:0]                tail_reg;
    logic [CNT_W-1:0]                count_reg;

    logic [cwfs_pkg::ENTRY_W-1:0]    queue_mem [QUEUE_DEPTH];
    logic [cwfs_pkg::ENTRY_W-1:0]    rd_data_reg;

    logic                            stage_valid_reg;
    logic [cwfs_pkg::KIND_W-1:0]     stage_kind_reg;
    logic [cwfs_pkg::TAG_W-1:0]      stage_tag_reg;

    logic                            m_valid_reg;
    logic [cwfs_pkg::KIND_W-1:0]     m_kind_reg;
    logic [cwfs_pkg::TAG_W-1:0]      m_tag_reg;
    logic                            m_last_reg;

    logic                            out_free;
    logic                            new_result;
    logic                            push_stage;
    logic [cwfs_pkg::KIND_W-1:0]     new_kind;
    logic [cwfs_pkg::TAG_W-1:0]      new_tag;
    logic                            head_final;

    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
        next_pos = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head_final = rd_data_reg[cwfs_pkg::ENTRY_W-1];
    assign out_free   = !m_valid_reg || m_ready;
    assign new_result = cmd.send_head || cmd.send_new || cmd.drop || cmd.emit_ack;
    assign push_stage = stage_valid_reg && (new_result || cmd.flush);

    always_comb begin
        new_kind = cwfs_pkg::KIND_FRAME;
        new_tag  = item_tag_reg;
        if (cmd.send_head) begin
            new_tag = rd_data_reg[cwfs_pkg::TAG_W-1:0];
        end else if (cmd.drop) begin
            new_kind = cwfs_pkg::KIND_DROP;
        end else if (cmd.emit_ack) begin
            new_kind = cwfs_pkg::KIND_ACK;
            new_tag  = '0;
        end
    end

    always_comb begin
        status.req_type      = item_type_reg;
        status.frame_final   = item_final_reg;
        status.data_present  = item_payload_reg;
        status.head_ok       = (count_reg != '0) && (head_final || credit_reg != '0);
        status.credit_zero   = (credit_reg == '0);
        status.queue_full    = (count_reg == CNT_W'(QUEUE_DEPTH));
        status.stage_blocked = stage_valid_reg && !out_free;
    end

    // held transaction fields
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_type_reg    <= s_req_type;
            item_tag_reg     <= s_frame_tag;
            item_final_reg   <= s_is_final;
            item_payload_reg <= s_has_payload;
        end
    end

    // credit and queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= cwfs_pkg::CREDIT_RESET;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
        end else begin
            if (cfg_write) begin
                credit_reg <= cfg_initial_window;
            end else if (cmd.credit_inc) begin
                if (credit_reg != cwfs_pkg::CREDIT_MAX) begin
                    credit_reg <= credit_reg + 1'b1;
                end
            end else if (cmd.send_head && !head_final) begin
                credit_reg <= credit_reg - 1'b1;
            end else if (cmd.send_new && !item_final_reg) begin
                credit_reg <= credit_reg - 1'b1;
            end
            if (cmd.send_head) begin
                head_reg  <= next_pos(head_reg);
                count_reg <= count_reg - 1'b1;
            end else if (cmd.enqueue) begin
                tail_reg  <= next_pos(tail_reg);
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // pending frame store
    always_ff @(posedge aclk) begin
        if (cmd.enqueue) begin
            queue_mem[tail_reg] <= {item_final_reg, item_tag_reg};
        end
        rd_data_reg <= queue_mem[head_reg];
    end

    // stage and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (new_result) begin
                stage_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                stage_valid_reg <= 1'b0;
            end
            if (push_stage) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (new_result) begin
            stage_kind_reg <= new_kind;
            stage_tag_reg  <= new_tag;
        end
        if (push_stage) begin
            m_kind_reg <= stage_kind_reg;
            m_tag_reg  <= stage_tag_reg;
            m_last_reg <= cmd.flush;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_kind = m_kind_reg;
    assign m_out_tag  = m_tag_reg;
    assign m_last     = m_last_reg;

endmodule

### rtl/cwfs_checker.sv
// ----------------------------------------------------------------------------
// cwfs_checker: port-level checks for credit_window_frame_sender
// Watches the result channel and the input handshake over time.
// ----------------------------------------------------------------------------
module cwfs_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [cwfs_pkg::KIND_W-1:0] m_out_kind,
    input logic [cwfs_pkg::TAG_W-1:0]  m_out_tag,
    input logic                        m_last
);

    // a stalled result stays offered
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn while stalled");

    // one transaction at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a transaction is in progress");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_kind == cwfs_pkg::KIND_FRAME ||
                     m_out_kind == cwfs_pkg::KIND_ACK ||
                     m_out_kind == cwfs_pkg::KIND_DROP))
        else $error("undefined result kind");

    a_ack_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_kind == cwfs_pkg::KIND_ACK |-> m_out_tag == '0)
        else $error("ack carries a nonzero tag");

    // acks and drops always close a transaction's results
    a_ack_drop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_kind != cwfs_pkg::KIND_FRAME |-> m_last)
        else $error("ack or drop not marked last");

endmodule

bind credit_window_frame_sender cwfs_checker u_cwfs_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_kind (m_out_kind),
    .m_out_tag  (m_out_tag),
    .m_last     (m_last)
);
